// File: design/cnsp_pkg.sv
`default_nettype none
package cnsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NAME    = 3'd1,
        PH_NAMEPAD = 3'd2,
        PH_DATA    = 3'd3,
        PH_DATAPAD = 3'd4,
        PH_END     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] name_length;
        logic [31:0] file_length;
        logic        last;
        logic        is_trailer;
    } t_result;

    localparam logic [31:0] HDR_LAST   = 32'd109;
    localparam logic [31:0] FSIZE_AT   = 32'd54;
    localparam logic [31:0] NSIZE_AT   = 32'd94;
    localparam logic [31:0] HEX_DIGITS = 32'd8;
    localparam logic [31:0] MAGIC_LEN  = 32'd6;
    localparam logic [31:0] TRAIL_LEN  = 32'd10;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    // "070701"
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h30;
            3'd1: c = 8'h37;
            3'd2: c = 8'h30;
            3'd3: c = 8'h37;
            3'd4: c = 8'h30;
            3'd5: c = 8'h31;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "TRAILER!!!"
    function automatic logic [7:0] trail_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0: c = 8'h54;
            4'd1: c = 8'h52;
            4'd2: c = 8'h41;
            4'd3: c = 8'h49;
            4'd4: c = 8'h4C;
            4'd5: c = 8'h45;
            4'd6: c = 8'h52;
            4'd7: c = 8'h21;
            4'd8: c = 8'h21;
            4'd9: c = 8'h21;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/cnsp_parse.sv
`default_nettype none
module cnsp_parse import cnsp_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_restart,
    output logic            o_has_result,
    output t_result         o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [31:0] r_nsize, n_nsize;
    logic [31:0] r_fsize, n_fsize;
    logic        r_tmatch, n_tmatch;
    logic [1:0]  r_align, n_align;

    // state as seen by this byte, after an optional restart
    t_phase      c_phase;
    logic [31:0] c_count;
    logic [31:0] c_nsize;
    logic [31:0] c_fsize;
    logic        c_tmatch;
    logic [1:0]  c_align;

    logic [32:0] count_inc;
    logic [1:0]  align_inc;
    logic        magic_bad;
    logic        in_fsize;
    logic        in_nsize;
    logic [31:0] fsize_upd;
    logic [31:0] nsize_upd;
    logic        tmatch_upd;
    logic        name_done;
    logic        data_done;
    logic        trailer_hit;
    logic [3:0]  hex;

    assign c_phase  = i_restart ? PH_HEADER : r_phase;
    assign c_count  = i_restart ? 32'd0 : r_count;
    assign c_nsize  = i_restart ? 32'd0 : r_nsize;
    assign c_fsize  = i_restart ? 32'd0 : r_fsize;
    assign c_tmatch = i_restart ? 1'b1 : r_tmatch;
    assign c_align  = i_restart ? 2'd0 : r_align;

    assign count_inc = {1'b0, c_count} + 33'd1;
    assign align_inc = c_align + 2'd1;
    assign hex       = hex_value(i_byte);

    assign magic_bad = (c_count < MAGIC_LEN) && (i_byte != magic_char(c_count[2:0]));
    assign in_fsize  = (c_count >= FSIZE_AT) && (c_count < FSIZE_AT + HEX_DIGITS);
    assign in_nsize  = (c_count >= NSIZE_AT) && (c_count < NSIZE_AT + HEX_DIGITS);
    assign fsize_upd = in_fsize ? {c_fsize[27:0], hex} : c_fsize;
    assign nsize_upd = in_nsize ? {c_nsize[27:0], hex} : c_nsize;

    assign tmatch_upd  = c_tmatch &&
                         !((c_count < TRAIL_LEN) && (i_byte != trail_char(c_count[3:0])));
    assign name_done   = count_inc >= {1'b0, c_nsize};
    assign data_done   = count_inc >= {1'b0, c_fsize};
    assign trailer_hit = tmatch_upd && (c_nsize >= TRAIL_LEN);

    // next state
    always_comb begin
        n_phase  = c_phase;
        n_count  = c_count;
        n_nsize  = c_nsize;
        n_fsize  = c_fsize;
        n_tmatch = c_tmatch;
        n_align  = c_align;
        unique case (c_phase)
            PH_HEADER: begin
                n_align = align_inc;
                if (magic_bad) begin
                    n_phase = PH_END;
                end else begin
                    n_fsize = fsize_upd;
                    n_nsize = nsize_upd;
                    if (c_count != HDR_LAST) begin
                        n_count = count_inc[31:0];
                    end else begin
                        n_tmatch = 1'b1;
                        n_count  = 32'd0;
                        if (nsize_upd != 32'd0) begin
                            n_phase = PH_NAME;
                        end else if (align_inc != 2'd0) begin
                            n_phase = PH_NAMEPAD;
                        end else begin
                            n_phase = (fsize_upd == 32'd0) ? PH_HEADER : PH_DATA;
                        end
                    end
                end
            end
            PH_NAME: begin
                n_align  = align_inc;
                n_tmatch = tmatch_upd;
                if (name_done) begin
                    n_count = 32'd0;
                    if (trailer_hit) begin
                        n_phase = PH_END;
                    end else if (align_inc != 2'd0) begin
                        n_phase = PH_NAMEPAD;
                    end else begin
                        n_phase = (c_fsize == 32'd0) ? PH_HEADER : PH_DATA;
                    end
                end else begin
                    n_count = count_inc[31:0];
                end
            end
            PH_NAMEPAD: begin
                n_align = align_inc;
                if (align_inc == 2'd0) begin
                    n_count = 32'd0;
                    n_phase = (c_fsize == 32'd0) ? PH_HEADER : PH_DATA;
                end
            end
            PH_DATA: begin
                n_align = align_inc;
                if (data_done) begin
                    n_count = 32'd0;
                    n_phase = (align_inc == 2'd0) ? PH_HEADER : PH_DATAPAD;
                end else begin
                    n_count = count_inc[31:0];
                end
            end
            PH_DATAPAD: begin
                n_align = align_inc;
                if (align_inc == 2'd0) begin
                    n_count = 32'd0;
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_phase = c_phase;
            end
        endcase
    end

    // result
    always_comb begin
        o_has_result = 1'b0;
        o_result     = '0;
        unique case (c_phase)
            PH_HEADER: begin
                if (magic_bad) begin
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_ERROR;
                end else if (c_count == HDR_LAST) begin
                    o_has_result         = 1'b1;
                    o_result.kind        = KIND_HEADER;
                    o_result.name_length = nsize_upd;
                    o_result.file_length = fsize_upd;
                end
            end
            PH_NAME: begin
                o_has_result          = 1'b1;
                o_result.kind         = KIND_NAME;
                o_result.payload_byte = i_byte;
                o_result.last         = name_done;
                o_result.is_trailer   = name_done && trailer_hit;
            end
            PH_DATA: begin
                o_has_result          = 1'b1;
                o_result.kind         = KIND_DATA;
                o_result.payload_byte = i_byte;
                o_result.last         = data_done;
            end
            default: begin
                o_has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_count  <= 32'd0;
            r_nsize  <= 32'd0;
            r_fsize  <= 32'd0;
            r_tmatch <= 1'b1;
            r_align  <= 2'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_nsize  <= n_nsize;
            r_fsize  <= n_fsize;
            r_tmatch <= n_tmatch;
            r_align  <= n_align;
        end
    end

endmodule
`default_nettype wire

// File: design/cpio_newc_stream_parser.sv
// Path: an accepted word is captured in the input register, then parsed and captured in the output register.
// Throughput: one archive byte per cycle, sustained while the output side takes results.
// Rate is set by the input register -> parse logic -> output register path.
// Reset: synchronous, active low; empties both registers and returns the parser to
// the start of an archive header.
`default_nettype none
module cpio_newc_stream_parser import cnsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_archive_byte,
    input  wire logic        i_restart,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_payload_byte,
    output logic [31:0]      o_name_length,
    output logic [31:0]      o_file_length,
    output logic             o_last,
    output logic             o_is_trailer
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_restart;
    logic       r_out_valid;
    t_result    r_out;

    logic       out_free;
    logic       step;
    logic       has_result;
    t_result    result;

    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;

    cnsp_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_byte       (r_in_byte),
        .i_restart    (r_in_restart),
        .o_has_result (has_result),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte    <= i_archive_byte;
            r_in_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && step && has_result) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_name_length  = r_out.name_length;
    assign o_file_length  = r_out.file_length;
    assign o_last         = r_out.last;
    assign o_is_trailer   = r_out.is_trailer;

endmodule
`default_nettype wire

// File: design/cnsp_checker.sv
`default_nettype none
module cnsp_checker import cnsp_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_payload_byte,
    input wire logic [31:0] o_name_length,
    input wire logic [31:0] o_file_length,
    input wire logic        o_last,
    input wire logic        o_is_trailer
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_payload_byte) && $stable(o_last))
        else $error("stalled result changed");

    a_trailer_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_trailer |-> o_last && (o_kind == KIND_NAME))
        else $error("trailer flag off the final name word");

    a_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_kind == KIND_HEADER) || (o_kind == KIND_ERROR))
            |-> (o_payload_byte == 8'd0) && !o_last && !o_is_trailer)
        else $error("header or error result carries byte fields");

    a_sizes_header_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_HEADER)
            |-> (o_name_length == 32'd0) && (o_file_length == 32'd0))
        else $error("sizes outside header result");

endmodule

bind cpio_newc_stream_parser cnsp_checker u_cnsp_checker (.*);
`default_nettype wire
